// ===== src/pcxrle_pkg.sv =====
// ----------------------------------------------------------------------------
// pcxrle_pkg
// Shared constants and control/status types of the pcx run-length decoder.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

  localparam int unsigned COUNT_WIDTH = 24;
  localparam int unsigned LEN_WIDTH   = 24;
  localparam int unsigned RUN_WIDTH   = 6;

  localparam logic [LEN_WIDTH-1:0]   LEN_RESET = LEN_WIDTH'(4096);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = {COUNT_WIDTH{1'b1}};

  // top two bits set marks a run marker
  localparam logic [1:0] MARKER_BITS = 2'b11;

  // configuration register word indexes
  localparam logic REG_OUTPUT_LENGTH = 1'b0;

  // controller -> datapath
  typedef struct packed {
    logic take;       // latch the source byte and the last flag
    logic arm_run;    // run marker seen: keep its count
    logic end_run;    // run finished or dropped
    logic emit_lit;   // load output with the incoming literal
    logic emit_run;   // load output with the held run value
    logic emit_done;  // load the final result and rearm
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;   // output register can be loaded this cycle
    logic full_now;   // image reached its length
    logic awaiting;   // next byte is the value of a run
    logic pend_zero;  // no run bytes left
    logic marker;     // incoming byte is a run marker
    logic last_q;     // held last flag of the current item
  } status_t;

endpackage

// ===== src/pcx_rle_decoder.sv =====
// ----------------------------------------------------------------------------
// pcx_rle_decoder
// PCX run-length decoder: source byte stream in, decoded bytes and a final
// pass/fail result out, with an APB register for the image length.
// ----------------------------------------------------------------------------
// result: every result is registered in the output register before it shows
// input: a literal or marker byte is taken in the idle state; a run value byte
//   with a nonzero count holds the input (one byte a cycle while the output is
//   free, then a step to close the run); a closing literal adds the done state
// reset: asynchronous, active low; clears the decode state, output length
//   returns to 4096
// ----------------------------------------------------------------------------
module pcx_rle_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // source stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_in
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [8] success, rest zero
  output logic [0:0]  m_axis_tuser,   // [0] has_byte
  output logic        m_axis_tlast,   // done_res
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pcxrle_pkg::*;

  logic [LEN_WIDTH-1:0] len_q;
  cmd_t                 cmd;
  status_t              status;
  logic                 out_has;
  logic [7:0]           out_byte;
  logic                 out_ok;
  logic                 reg_sel;

  // ---- register file: one word, output_length at byte address 0 ----------
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_OUTPUT_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      len_q <= pwdata[LEN_WIDTH-1:0];
    end
  end

  // reads of any other word return zero
  assign prdata = reg_sel ? 32'(len_q) : 32'h0;

  // ---- controller: accepts bytes, sequences runs and the final result -----
  pcxrle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // ---- datapath: run count, byte counter, fullness, output register -------
  pcxrle_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .len_i       (len_q),
    .byte_i      (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_has_o   (out_has),
    .out_byte_o  (out_byte),
    .out_done_o  (m_axis_tlast),
    .out_ok_o    (out_ok)
  );

  // pack result fields
  assign m_axis_tdata = {7'b0, out_ok, out_byte};
  assign m_axis_tuser = out_has;

  // ---- checks ---------------------------------------------------------------
  // a result is never loaded over one still waiting downstream
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_lit || cmd.emit_run || cmd.emit_done) |-> status.out_free)
    else $error("result loaded while output register is occupied");

  // no byte is taken while the output register cannot take a result
  a_ready_needs_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !status.out_free |-> !s_axis_tready)
    else $error("input ready while output register is blocked");

  // a final result rearms the decode
  a_rearm : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_done |=> (!status.awaiting && status.pend_zero))
    else $error("decode state not cleared after final result");

  // the final result is shown with no decoded byte
  a_done_no_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_done |=> (m_axis_tvalid && m_axis_tlast && !m_axis_tuser[0]))
    else $error("final result malformed");

endmodule

// ===== src/pcxrle_dp.sv =====
// ----------------------------------------------------------------------------
// pcxrle_dp
// Decoder datapath: run state, byte counter, fullness and output register.
// ----------------------------------------------------------------------------
module pcxrle_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pcxrle_pkg::cmd_t               cmd_i,
  output pcxrle_pkg::status_t            status_o,
  input  logic [pcxrle_pkg::LEN_WIDTH-1:0] len_i,
  input  logic [7:0]                     byte_i,
  input  logic                           last_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           out_has_o,
  output logic [7:0]                     out_byte_o,
  output logic                           out_done_o,
  output logic                           out_ok_o
);
  import pcxrle_pkg::*;

  logic                   awaiting_q, awaiting_d;
  logic [RUN_WIDTH-1:0]   pend_q, pend_d;
  logic [COUNT_WIDTH-1:0] bw_q, bw_d;
  logic                   full_q, full_d;
  logic                   valid_q, valid_d;
  logic [7:0]             val_q;
  logic                   last_q;
  logic                   has_q, done_q, ok_q;
  logic [7:0]             obyte_q;

  logic [COUNT_WIDTH-1:0] len_ext;
  logic [COUNT_WIDTH-1:0] bw_inc;
  logic                   full_now;
  logic                   load;

  assign len_ext  = COUNT_WIDTH'(len_i);
  assign bw_inc   = (bw_q == CNT_MAX) ? bw_q : bw_q + 1'b1;
  assign full_now = full_q | (bw_q >= len_ext);
  assign load     = cmd_i.emit_lit | cmd_i.emit_run | cmd_i.emit_done;

  always_comb begin
    awaiting_d = awaiting_q;
    pend_d     = pend_q;
    bw_d       = bw_q;
    full_d     = full_q;
    valid_d    = valid_q;
    if (cmd_i.take) begin
      full_d = full_now;
    end
    if (cmd_i.arm_run) begin
      awaiting_d = 1'b1;
      pend_d     = byte_i[RUN_WIDTH-1:0];
    end
    if (cmd_i.end_run) begin
      awaiting_d = 1'b0;
      pend_d     = '0;
    end
    if (cmd_i.emit_lit || cmd_i.emit_run) begin
      bw_d   = bw_inc;
      full_d = full_now | (bw_inc >= len_ext);
    end
    if (cmd_i.emit_run) begin
      pend_d = pend_q - 1'b1;
    end
    if (cmd_i.emit_done) begin
      awaiting_d = 1'b0;
      pend_d     = '0;
      bw_d       = '0;
      full_d     = 1'b0;
    end
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b0;
      pend_q     <= '0;
      bw_q       <= '0;
      full_q     <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      awaiting_q <= awaiting_d;
      pend_q     <= pend_d;
      bw_q       <= bw_d;
      full_q     <= full_d;
      valid_q    <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      val_q  <= byte_i;
      last_q <= last_i;
    end
    if (cmd_i.emit_done) begin
      has_q   <= 1'b0;
      obyte_q <= 8'h00;
      done_q  <= 1'b1;
      ok_q    <= (bw_q == len_ext);
    end else if (cmd_i.emit_lit) begin
      has_q   <= 1'b1;
      obyte_q <= byte_i;
      done_q  <= 1'b0;
      ok_q    <= 1'b0;
    end else if (cmd_i.emit_run) begin
      has_q   <= 1'b1;
      obyte_q <= val_q;
      done_q  <= 1'b0;
      ok_q    <= 1'b0;
    end
  end

  assign status_o.out_free  = ~valid_q | out_ready_i;
  assign status_o.full_now  = full_now;
  assign status_o.awaiting  = awaiting_q;
  assign status_o.pend_zero = (pend_q == '0);
  assign status_o.marker    = (byte_i[7:6] == MARKER_BITS);
  assign status_o.last_q    = last_q;

  assign out_valid_o = valid_q;
  assign out_has_o   = has_q;
  assign out_byte_o  = obyte_q;
  assign out_done_o  = done_q;
  assign out_ok_o    = ok_q;

endmodule

// ===== src/pcxrle_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcxrle_ctrl
// Decoder controller: takes source bytes and sequences run and final results.
// ----------------------------------------------------------------------------
module pcxrle_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  output logic                in_ready_o,
  input  pcxrle_pkg::status_t status_i,
  output pcxrle_pkg::cmd_t    cmd_o
);
  import pcxrle_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_q, state_d;
  logic       take;

  assign in_ready_o = (state_q == ST_IDLE) & status_i.out_free;
  assign take       = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          cmd_o.take = 1'b1;
          if (status_i.full_now) begin
            cmd_o.emit_done = in_last_i;
          end else if (status_i.awaiting) begin
            if (status_i.pend_zero) begin
              cmd_o.end_run   = 1'b1;
              cmd_o.emit_done = in_last_i;
            end else begin
              state_d = ST_RUN;
            end
          end else if (status_i.marker) begin
            cmd_o.arm_run   = 1'b1;
            cmd_o.emit_done = in_last_i;
          end else begin
            cmd_o.emit_lit = 1'b1;
            if (in_last_i) begin
              state_d = ST_DONE;
            end
          end
        end
      end
      ST_RUN: begin
        if (status_i.out_free) begin
          if (status_i.full_now || status_i.pend_zero) begin
            cmd_o.end_run   = 1'b1;
            cmd_o.emit_done = status_i.last_q;
            state_d         = ST_IDLE;
          end else begin
            cmd_o.emit_run = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.emit_done = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
